// ===== design/dbr_pkg.sv =====
// Shared types and constants for the DAG backward reachability marker.
// No dependencies; used by dbr_ctrl, dbr_dp and the top level.
`default_nettype none
package dbr_pkg;

  localparam int NODE_CAP = 64;
  localparam int EDGE_CAP = 256;

  localparam int NODE_W = (NODE_CAP > 1) ? $clog2(NODE_CAP) : 1;
  localparam int NCNT_W = $clog2(NODE_CAP + 1);
  localparam int EDGE_W = (EDGE_CAP > 1) ? $clog2(EDGE_CAP) : 1;
  localparam int ECNT_W = $clog2(EDGE_CAP + 1);

  // port field widths
  localparam int KIND_W    = 2;
  localparam int NODE_ID_W = 6;
  localparam int MAXN_W    = 7;
  localparam int STATUS_W  = 2;
  localparam int INDEX_W   = 8;
  localparam int MASK_W    = 64;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR    = 2'd0,
    KIND_ADD_NODE = 2'd1,
    KIND_ADD_EDGE = 2'd2,
    KIND_MARK     = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_EDGE = 2'd2,
    ST_EMPTY    = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EDGE_WR,
    S_NODE_SCAN,
    S_HEAD_WAIT,
    S_EDGE_WAIT
  } state_t;

  typedef enum logic [1:0] {
    IDX_NONE,
    IDX_NODE,
    IDX_EDGE
  } idx_sel_t;

  typedef enum logic {
    EA_HEAD,
    EA_LINK
  } edge_addr_sel_t;

  // one entry of the edge store: link to the next older incoming edge
  typedef struct packed {
    logic              more;
    logic [EDGE_W-1:0] link;
    logic [NODE_W-1:0] src;
  } edge_word_t;

  typedef struct packed {
    logic           do_clear;
    logic           do_add_node;
    logic           edge_latch;
    logic           edge_wr;
    logic           mark_init;
    logic           node_rd;
    logic           edge_rd;
    edge_addr_sel_t edge_addr_sel;
    logic           set_src;
    logic           t_dec;
    logic           out_load;
    status_t        out_status;
    idx_sel_t       out_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
    logic node_full;
    logic edge_full;
    logic edge_bad;
    logic graph_empty;
    logic mark_last_zero;
    logic node_hit;
    logic link_more;
    logic t_one;
  } dp_stat_t;

endpackage
`default_nettype wire

// ===== design/dbr_ctrl.sv =====
// Controller of the reachability marker: sequences loads and the mark walk.
// Depends on dbr_pkg; drives dbr_dp through ctrl_cmd_t.
`default_nettype none
module dbr_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire dbr_pkg::kind_t    kind,
  input  wire dbr_pkg::dp_stat_t st,
  output dbr_pkg::ctrl_cmd_t     cmd
);

  dbr_pkg::state_t state;
  dbr_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dbr_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      dbr_pkg::S_IDLE: begin
        if (in_valid && st.out_free) begin
          if (kind == dbr_pkg::KIND_ADD_EDGE && !st.edge_bad && !st.edge_full) begin
            state_next = dbr_pkg::S_EDGE_WR;
          end else if (kind == dbr_pkg::KIND_MARK && !st.graph_empty &&
                       !st.mark_last_zero) begin
            state_next = dbr_pkg::S_NODE_SCAN;
          end
        end
      end
      dbr_pkg::S_EDGE_WR: state_next = dbr_pkg::S_IDLE;
      dbr_pkg::S_NODE_SCAN: begin
        if (st.node_hit) begin
          state_next = dbr_pkg::S_HEAD_WAIT;
        end else if (st.t_one) begin
          state_next = dbr_pkg::S_IDLE;
        end
      end
      dbr_pkg::S_HEAD_WAIT: state_next = dbr_pkg::S_EDGE_WAIT;
      dbr_pkg::S_EDGE_WAIT: begin
        if (st.link_more) begin
          state_next = dbr_pkg::S_EDGE_WAIT;
        end else if (st.t_one) begin
          state_next = dbr_pkg::S_IDLE;
        end else begin
          state_next = dbr_pkg::S_NODE_SCAN;
        end
      end
      default: state_next = dbr_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      dbr_pkg::S_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          case (kind)
            dbr_pkg::KIND_CLEAR: begin
              cmd.do_clear   = 1'b1;
              cmd.out_load   = 1'b1;
              cmd.out_status = dbr_pkg::ST_OK;
            end
            dbr_pkg::KIND_ADD_NODE: begin
              cmd.out_load = 1'b1;
              if (st.node_full) begin
                cmd.out_status = dbr_pkg::ST_FULL;
              end else begin
                cmd.do_add_node = 1'b1;
                cmd.out_status  = dbr_pkg::ST_OK;
                cmd.out_idx     = dbr_pkg::IDX_NODE;
              end
            end
            dbr_pkg::KIND_ADD_EDGE: begin
              if (st.edge_bad) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = dbr_pkg::ST_BAD_EDGE;
              end else if (st.edge_full) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = dbr_pkg::ST_FULL;
              end else begin
                cmd.edge_latch = 1'b1;
              end
            end
            dbr_pkg::KIND_MARK: begin
              if (st.graph_empty) begin
                cmd.out_load   = 1'b1;
                cmd.out_status = dbr_pkg::ST_EMPTY;
              end else begin
                cmd.mark_init = 1'b1;
                // only node 0 in the prefix: nothing to walk
                if (st.mark_last_zero) begin
                  cmd.out_load   = 1'b1;
                  cmd.out_status = dbr_pkg::ST_OK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      dbr_pkg::S_EDGE_WR: begin
        cmd.edge_wr    = 1'b1;
        cmd.out_load   = 1'b1;
        cmd.out_status = dbr_pkg::ST_OK;
        cmd.out_idx    = dbr_pkg::IDX_EDGE;
      end
      dbr_pkg::S_NODE_SCAN: begin
        if (st.node_hit) begin
          cmd.node_rd = 1'b1;
        end else if (st.t_one) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = dbr_pkg::ST_OK;
        end else begin
          cmd.t_dec = 1'b1;
        end
      end
      dbr_pkg::S_HEAD_WAIT: begin
        cmd.edge_rd       = 1'b1;
        cmd.edge_addr_sel = dbr_pkg::EA_HEAD;
      end
      dbr_pkg::S_EDGE_WAIT: begin
        cmd.set_src = 1'b1;
        if (st.link_more) begin
          cmd.edge_rd       = 1'b1;
          cmd.edge_addr_sel = dbr_pkg::EA_LINK;
        end else if (st.t_one) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = dbr_pkg::ST_OK;
        end else begin
          cmd.t_dec = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // a result is only ever written into a free output register
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded over a pending word");

  // the head pointer used by the walk must come from a head read in the cycle before
  a_head_read: assert property (@(posedge clk) disable iff (rst)
    state == dbr_pkg::S_HEAD_WAIT |-> $past(cmd.node_rd))
    else $error("edge walk started without a head read");

endmodule
`default_nettype wire

// ===== design/dbr_dp.sv =====
// Datapath of the reachability marker: counters, flags, head and edge stores,
// mark walk pointer and output register. Depends on dbr_pkg; driven by dbr_ctrl.
`default_nettype none
module dbr_dp (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire dbr_pkg::ctrl_cmd_t                cmd,
  output dbr_pkg::dp_stat_t                      st,
  input  wire logic [dbr_pkg::NODE_ID_W-1:0]     src_node,
  input  wire logic [dbr_pkg::NODE_ID_W-1:0]     dst_node,
  input  wire logic signed [dbr_pkg::MAXN_W-1:0] max_node,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dbr_pkg::STATUS_W-1:0]           status,
  output logic [dbr_pkg::INDEX_W-1:0]            index,
  output logic [dbr_pkg::MASK_W-1:0]             active_mask
);

  localparam int NW = dbr_pkg::NODE_W;
  localparam int EW = dbr_pkg::EDGE_W;
  localparam int CW = dbr_pkg::NODE_ID_W + 1;

  logic [dbr_pkg::NCNT_W-1:0]   node_total;
  logic [dbr_pkg::ECNT_W-1:0]   edge_total;
  logic [dbr_pkg::NODE_CAP-1:0] flags;
  logic [dbr_pkg::NODE_CAP-1:0] flags_next;
  logic [dbr_pkg::NODE_CAP-1:0] head_valid;
  logic [NW-1:0]                t;
  logic [NW-1:0]                src_q;
  logic [NW-1:0]                dst_q;
  logic [EW-1:0]                head_rdata;
  dbr_pkg::edge_word_t          edge_rdata;
  dbr_pkg::status_t             out_status;

  logic [EW-1:0]             head_mem [dbr_pkg::NODE_CAP];
  dbr_pkg::edge_word_t       edge_mem [dbr_pkg::EDGE_CAP];

  logic [dbr_pkg::NCNT_W-1:0]   node_last;
  logic [NW-1:0]                mark_last;
  logic [dbr_pkg::NODE_CAP-1:0] below;
  logic [dbr_pkg::NODE_CAP-1:0] last_bit;
  logic [NW-1:0]                head_raddr;
  logic [EW-1:0]                edge_raddr;

  // last node of the mark prefix
  always_comb begin
    node_last = node_total - dbr_pkg::NCNT_W'(1);
    if (!max_node[dbr_pkg::MAXN_W-1] &&
        CW'(max_node[dbr_pkg::NODE_ID_W-1:0]) < CW'(node_total)) begin
      mark_last = NW'(max_node[dbr_pkg::NODE_ID_W-1:0]);
    end else begin
      mark_last = node_last[NW-1:0];
    end
    for (int i = 0; i < dbr_pkg::NODE_CAP; i++) begin
      below[i] = (NW'(i) <= mark_last);
    end
    last_bit = {{(dbr_pkg::NODE_CAP-1){1'b0}}, 1'b1} << mark_last;
  end

  always_comb begin
    flags_next = flags;
    if (cmd.do_clear) begin
      flags_next = '0;
    end
    if (cmd.do_add_node) begin
      flags_next[node_total[NW-1:0]] = 1'b0;
    end
    if (cmd.mark_init) begin
      flags_next = (flags & ~below) | last_bit;
    end
    if (cmd.set_src) begin
      flags_next[edge_rdata.src] = 1'b1;
    end
  end

  always_comb begin
    st.out_free       = !out_valid || out_ready;
    st.node_full      = (node_total == dbr_pkg::NCNT_W'(dbr_pkg::NODE_CAP));
    st.edge_full      = (edge_total == dbr_pkg::ECNT_W'(dbr_pkg::EDGE_CAP));
    st.edge_bad       = (src_node >= dst_node) || (CW'(dst_node) >= CW'(node_total));
    st.graph_empty    = (node_total == '0);
    st.mark_last_zero = (mark_last == '0);
    st.node_hit       = flags[t] && head_valid[t];
    st.link_more      = edge_rdata.more;
    st.t_one          = (t == NW'(1));
  end

  assign head_raddr = cmd.edge_latch ? NW'(dst_node) : t;
  assign edge_raddr = (cmd.edge_addr_sel == dbr_pkg::EA_HEAD) ? head_rdata : edge_rdata.link;

  always_ff @(posedge clk) begin
    if (rst) begin
      node_total <= '0;
      edge_total <= '0;
      flags      <= '0;
      head_valid <= '0;
      out_valid  <= 1'b0;
    end else begin
      flags <= flags_next;
      if (cmd.do_clear) begin
        node_total <= '0;
        edge_total <= '0;
        head_valid <= '0;
      end
      if (cmd.do_add_node) begin
        node_total                      <= node_total + dbr_pkg::NCNT_W'(1);
        head_valid[node_total[NW-1:0]]  <= 1'b0;
      end
      if (cmd.edge_wr) begin
        edge_total        <= edge_total + dbr_pkg::ECNT_W'(1);
        head_valid[dst_q] <= 1'b1;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.edge_latch) begin
      src_q <= NW'(src_node);
      dst_q <= NW'(dst_node);
    end
    if (cmd.mark_init) begin
      t <= mark_last;
    end else if (cmd.t_dec) begin
      t <= t - NW'(1);
    end
    if (cmd.out_load) begin
      out_status  <= cmd.out_status;
      active_mask <= dbr_pkg::MASK_W'(flags_next);
      case (cmd.out_idx)
        dbr_pkg::IDX_NODE: index <= dbr_pkg::INDEX_W'(node_total);
        dbr_pkg::IDX_EDGE: index <= dbr_pkg::INDEX_W'(edge_total);
        default:           index <= '0;
      endcase
    end
  end

  // head pointer store: newest incoming edge of each node
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      head_mem[dst_q] <= edge_total[EW-1:0];
    end
    if (cmd.edge_latch || cmd.node_rd) begin
      head_rdata <= head_mem[head_raddr];
    end
  end

  // edge store: source node and link to the next older edge of the same node
  always_ff @(posedge clk) begin
    if (cmd.edge_wr) begin
      edge_mem[edge_total[EW-1:0]] <= '{more: head_valid[dst_q], link: head_rdata, src: src_q};
    end
    if (cmd.edge_rd) begin
      edge_rdata <= edge_mem[edge_raddr];
    end
  end

  assign status = out_status;

  a_edge_room: assert property (@(posedge clk) disable iff (rst)
    cmd.edge_wr |-> edge_total < dbr_pkg::ECNT_W'(dbr_pkg::EDGE_CAP))
    else $error("edge written into a full store");

  a_node_room: assert property (@(posedge clk) disable iff (rst)
    cmd.do_add_node |-> node_total < dbr_pkg::NCNT_W'(dbr_pkg::NODE_CAP))
    else $error("node added to a full graph");

  // topological order: every source reached from node t lies below it
  a_src_below: assert property (@(posedge clk) disable iff (rst)
    cmd.set_src |-> edge_rdata.src < t)
    else $error("walk flagged a source not below its node");

endmodule
`default_nettype wire

// ===== design/dag_backward_reachability_marker.sv =====
// DAG backward reachability marker, top level. Clear, add node and every error
// case load their result straight from idle; add edge reads the head pointer,
// then writes the edge and head. A mark is set up, then walks nodes from the
// last node of the prefix down to node 1: an unflagged or edgeless node is only
// checked, and for a flagged node the head pointer is read and its incoming
// edges are followed in turn through the single read port of the edge store.
// A new word is taken only when the output register is empty or being emptied
// in the same cycle. Depends on dbr_pkg, dbr_ctrl and dbr_dp.
`default_nettype none
module dag_backward_reachability_marker (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [dbr_pkg::KIND_W-1:0]        kind,
  input  wire logic [dbr_pkg::NODE_ID_W-1:0]     src_node,
  input  wire logic [dbr_pkg::NODE_ID_W-1:0]     dst_node,
  input  wire logic signed [dbr_pkg::MAXN_W-1:0] max_node,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic [dbr_pkg::STATUS_W-1:0]           status,
  output logic [dbr_pkg::INDEX_W-1:0]            index,
  output logic [dbr_pkg::MASK_W-1:0]             active_mask
);

  dbr_pkg::ctrl_cmd_t cmd;
  dbr_pkg::dp_stat_t  st;
  dbr_pkg::kind_t     kind_code;

  assign kind_code = dbr_pkg::kind_t'(kind);

  dbr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .kind     (kind_code),
    .st       (st),
    .cmd      (cmd)
  );

  dbr_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .src_node    (src_node),
    .dst_node    (dst_node),
    .max_node    (max_node),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .index       (index),
    .active_mask (active_mask)
  );

endmodule
`default_nettype wire
